### hdl/jsu_pkg.sv
// jsu_pkg: shared types, codes and helper functions of the json string unescaper
// used by every module of the block
package jsu_pkg;

  // decoder modes
  localparam logic [2:0] MODE_PLAIN   = 3'd0;
  localparam logic [2:0] MODE_ESC     = 3'd1;
  localparam logic [2:0] MODE_HEX     = 3'd2;
  localparam logic [2:0] MODE_HIGH    = 3'd3;
  localparam logic [2:0] MODE_HIGH_BS = 3'd4;
  localparam logic [2:0] MODE_LOW_HEX = 3'd5;

  // status codes
  localparam logic [3:0] ST_BUSY      = 4'd0;
  localparam logic [3:0] ST_CLOSED    = 4'd1;
  localparam logic [3:0] ST_UNTERM    = 4'd2;
  localparam logic [3:0] ST_CONTROL   = 4'd3;
  localparam logic [3:0] ST_OPEN_ESC  = 4'd4;
  localparam logic [3:0] ST_BAD_ESC   = 4'd5;
  localparam logic [3:0] ST_TRUNC_U   = 4'd6;
  localparam logic [3:0] ST_BAD_HEX   = 4'd7;
  localparam logic [3:0] ST_BAD_PAIR  = 4'd8;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // surrogate bounds
  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] SURR_END     = 16'hE000;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam int MAX_RESULTS = 4;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       last;
  } result_t;

  // all results caused by one input item
  typedef struct packed {
    logic [2:0]   count;
    result_t [3:0] res;
  } dec_t;

  // outcome of handling one byte as plain text or as an escape character
  typedef struct packed {
    logic       emit_byte;
    logic       emit_stat;
    logic [7:0] value;
    logic [3:0] stat;
    logic [2:0] mode_next;
    logic       hex_start;
  } act_t;

  // hex digit value, msb set when the byte is no hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
    else r = 5'h10;
    return r;
  endfunction

  // number of utf-8 bytes for a code point
  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] r;
    if (cp < 21'h80) r = 3'd1;
    else if (cp < 21'h800) r = 3'd2;
    else if (cp < 21'h10000) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

  // utf-8 bytes of a code point, first byte at index 0
  function automatic logic [3:0][7:0] utf8_bytes(input logic [20:0] cp);
    logic [3:0][7:0] r;
    r = '0;
    unique case (utf8_len(cp))
      3'd1: begin
        r[0] = cp[7:0];
      end
      3'd2: begin
        r[0] = {3'b110, cp[10:6]};
        r[1] = {2'b10, cp[5:0]};
      end
      3'd3: begin
        r[0] = {4'b1110, cp[15:12]};
        r[1] = {2'b10, cp[11:6]};
        r[2] = {2'b10, cp[5:0]};
      end
      default: begin
        r[0] = {5'b11110, cp[20:18]};
        r[1] = {2'b10, cp[17:12]};
        r[2] = {2'b10, cp[11:6]};
        r[3] = {2'b10, cp[5:0]};
      end
    endcase
    return r;
  endfunction

endpackage

### hdl/jsu_if.sv
// jsu_in_if / jsu_out_if: valid-ready channels of the json string unescaper
// no dependencies
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [3:0] status;
  logic       last;

  modport source (output valid, out_byte, byte_valid, status, last, input ready);
  modport sink (input valid, out_byte, byte_valid, status, last, output ready);
endinterface

### hdl/jsu_decode.sv
// jsu_decode: decoder state and the single-pass decode of one registered byte
// depends on jsu_pkg
module jsu_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          end_of_text,
  input  logic          advance,
  output jsu_pkg::dec_t dec
);
  import jsu_pkg::*;

  logic [2:0]  mode;
  logic [15:0] acc;
  logic [15:0] low;
  logic [1:0]  cnt;
  logic        bad;

  logic [2:0]  mode_next;
  logic [15:0] acc_next;
  logic [15:0] low_next;
  logic [1:0]  cnt_next;
  logic        bad_next;

  logic        emit_cp;
  logic [20:0] cp;
  logic        use_act;
  act_t        act;

  logic [4:0]  hv;
  logic        dig_bad;
  logic [15:0] acc_sh;
  logic [15:0] low_sh;

  logic [2:0]      cp_len;
  logic [3:0][7:0] cp_bytes;
  logic            tail;
  logic [2:0]      n;

  function automatic act_t stat_act(input logic [3:0] st);
    act_t a;
    a = '0;
    a.emit_stat = 1'b1;
    a.stat = st;
    a.mode_next = MODE_PLAIN;
    return a;
  endfunction

  // byte seen in plain text
  function automatic act_t plain_act(input logic [7:0] b);
    act_t a;
    a = '0;
    a.mode_next = MODE_PLAIN;
    if (b == CH_QUOTE) a = stat_act(ST_CLOSED);
    else if (b < CH_SPACE) a = stat_act(ST_CONTROL);
    else if (b == CH_BSLASH) a.mode_next = MODE_ESC;
    else begin
      a.emit_byte = 1'b1;
      a.value = b;
    end
    return a;
  endfunction

  // byte seen right after a backslash
  function automatic act_t escape_act(input logic [7:0] b);
    act_t a;
    a = '0;
    a.mode_next = MODE_PLAIN;
    a.emit_byte = 1'b1;
    case (b)
      CH_QUOTE:  a.value = CH_QUOTE;
      CH_BSLASH: a.value = CH_BSLASH;
      CH_SLASH:  a.value = CH_SLASH;
      CH_B:      a.value = 8'h08;
      CH_F:      a.value = 8'h0C;
      CH_N:      a.value = 8'h0A;
      CH_R:      a.value = 8'h0D;
      CH_T:      a.value = 8'h09;
      CH_U: begin
        a.emit_byte = 1'b0;
        a.mode_next = MODE_HEX;
        a.hex_start = 1'b1;
      end
      default:   a = stat_act(ST_BAD_ESC);
    endcase
    return a;
  endfunction

  // hex digit helpers
  assign hv      = hex_val(in_byte);
  assign dig_bad = bad | hv[4];
  assign acc_sh  = {acc[11:0], hv[3:0]};
  assign low_sh  = {low[11:0], hv[3:0]};

  // next state and what to emit
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    low_next  = low;
    cnt_next  = cnt;
    bad_next  = bad;
    emit_cp   = 1'b0;
    cp        = '0;
    use_act   = 1'b0;
    act       = '0;
    unique case (mode)
      MODE_ESC: begin
        use_act = 1'b1;
        act = end_of_text ? stat_act(ST_OPEN_ESC) : escape_act(in_byte);
      end
      MODE_HEX: begin
        if (end_of_text) begin
          use_act = 1'b1;
          act = stat_act(ST_TRUNC_U);
        end else begin
          bad_next = dig_bad;
          if (!hv[4]) acc_next = acc_sh;
          if (cnt != 2'd3) begin
            cnt_next = cnt + 2'd1;
          end else if (dig_bad) begin
            use_act = 1'b1;
            act = stat_act(ST_BAD_HEX);
          end else if (acc_sh >= HIGH_SURR_LO && acc_sh < LOW_SURR_LO) begin
            mode_next = MODE_HIGH;
          end else begin
            emit_cp = 1'b1;
            cp = {5'd0, acc_sh};
            mode_next = MODE_PLAIN;
          end
        end
      end
      MODE_HIGH: begin
        if (in_byte == CH_BSLASH && !end_of_text) begin
          mode_next = MODE_HIGH_BS;
        end else begin
          emit_cp = 1'b1;
          cp = {5'd0, acc};
          use_act = 1'b1;
          act = end_of_text ? stat_act(ST_UNTERM) : plain_act(in_byte);
        end
      end
      MODE_HIGH_BS: begin
        if (end_of_text) begin
          emit_cp = 1'b1;
          cp = {5'd0, acc};
          use_act = 1'b1;
          act = stat_act(ST_OPEN_ESC);
        end else if (in_byte == CH_U) begin
          mode_next = MODE_LOW_HEX;
          low_next = '0;
          cnt_next = '0;
          bad_next = 1'b0;
        end else begin
          emit_cp = 1'b1;
          cp = {5'd0, acc};
          use_act = 1'b1;
          act = escape_act(in_byte);
        end
      end
      MODE_LOW_HEX: begin
        if (end_of_text) begin
          use_act = 1'b1;
          act = stat_act(ST_TRUNC_U);
        end else begin
          bad_next = dig_bad;
          if (!hv[4]) low_next = low_sh;
          if (cnt != 2'd3) begin
            cnt_next = cnt + 2'd1;
          end else if (dig_bad) begin
            use_act = 1'b1;
            act = stat_act(ST_BAD_HEX);
          end else if (low_sh < LOW_SURR_LO || low_sh >= SURR_END) begin
            use_act = 1'b1;
            act = stat_act(ST_BAD_PAIR);
          end else begin
            // joined pair, then back to reset values
            emit_cp = 1'b1;
            cp = {1'b0, acc[9:0], low_sh[9:0]} + SUPP_BASE;
            mode_next = MODE_PLAIN;
            acc_next = '0;
            low_next = '0;
            cnt_next = '0;
            bad_next = 1'b0;
          end
        end
      end
      default: begin
        use_act = 1'b1;
        act = end_of_text ? stat_act(ST_UNTERM) : plain_act(in_byte);
      end
    endcase
    // outcome of plain or escape handling
    if (use_act) begin
      mode_next = act.mode_next;
      if (act.hex_start) begin
        acc_next = '0;
        cnt_next = '0;
        bad_next = 1'b0;
      end
      if (act.emit_stat) begin
        mode_next = MODE_PLAIN;
        acc_next  = '0;
        low_next  = '0;
        cnt_next  = '0;
        bad_next  = 1'b0;
      end
    end
  end

  // result assembly: code point bytes, then the trailing byte or status
  assign cp_len   = emit_cp ? utf8_len(cp) : 3'd0;
  assign cp_bytes = utf8_bytes(cp);
  assign tail     = use_act & (act.emit_byte | act.emit_stat);
  assign n        = cp_len + {2'd0, tail};

  always_comb begin
    dec.count = n;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      dec.res[i] = '0;
      if (3'(i) < cp_len) begin
        dec.res[i].out_byte   = cp_bytes[i];
        dec.res[i].byte_valid = 1'b1;
      end else if (3'(i) == cp_len && tail) begin
        dec.res[i].out_byte   = act.emit_byte ? act.value : 8'd0;
        dec.res[i].byte_valid = act.emit_byte;
        dec.res[i].status     = act.emit_stat ? act.stat : ST_BUSY;
      end
      dec.res[i].last = (3'(i) + 3'd1 == n);
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      acc  <= '0;
      low  <= '0;
      cnt  <= '0;
      bad  <= 1'b0;
    end else if (advance) begin
      mode <= mode_next;
      acc  <= acc_next;
      low  <= low_next;
      cnt  <= cnt_next;
      bad  <= bad_next;
    end
  end

endmodule

### hdl/jsu_result_buf.sv
// jsu_result_buf: four-entry result register that drains one beat per cycle while out_ch is ready
// depends on jsu_pkg and jsu_out_if
module jsu_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::dec_t    load_data,
  output logic             room,
  jsu_out_if.source        out_ch
);
  import jsu_pkg::*;

  result_t [3:0] res;
  logic [1:0]    head;
  logic [2:0]    cnt;
  logic          fire;
  result_t       cur;

  assign fire = out_ch.valid & out_ch.ready;
  assign room = (cnt == 3'd0) || (cnt == 3'd1 && fire);
  assign cur  = res[head];

  // output beat
  assign out_ch.valid      = (cnt != 3'd0);
  assign out_ch.out_byte   = cur.out_byte;
  assign out_ch.byte_valid = cur.byte_valid;
  assign out_ch.status     = cur.status;
  assign out_ch.last       = cur.last;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
    end else if (load) begin
      head <= '0;
      cnt  <= load_data.count;
    end else if (fire) begin
      head <= head + 2'd1;
      cnt  <= cnt - 3'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_data.res;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("result count above four");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> room)
    else $error("results loaded over undelivered beats");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    fire && !load && cnt > 3'd1 |=> cnt == $past(cnt) - 3'd1 && head == $past(head) + 2'd1)
    else $error("buffer did not advance on delivered beat");
`endif

endmodule

### hdl/json_string_unescape_utf8_top.sv
// json string unescaper to utf-8, top level
// holds the input register; depends on jsu_pkg, jsu_if, jsu_decode, jsu_result_buf
//
// in_ch carries one raw byte of a json string body per beat (after the opening
// quote), or an end_of_text marker with no byte. out_ch gives the decoded
// bytes one per beat, then a status beat on close or error; last marks the
// final beat caused by each input beat. Input beats that only consume a byte
// (escape start, hex digits, a high surrogate waiting for its partner) give
// no output beat.
// An accepted beat is held in the input register and is decoded into the result
// register when its results fit; out_ch is driven from the result register.
// Throughput: one input beat per cycle while each beat yields at most one
// result and out_ch is ready; a beat yielding more results holds the input
// until the single output port drains the four-entry result register.
// Reset (rst, synchronous) empties both registers and returns the decoder to
// plain text. When out_ch stalls, results wait in the result register and
// in_ch stops taking beats once the input register is also full.
module json_string_unescape_utf8_top (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_eot;
  logic       advance;
  logic       buf_room;
  dec_t       dec;

  // item leaves the input register when its results fit
  assign advance     = inq_valid && (dec.count == 3'd0 || buf_room);
  assign in_ch.ready = !inq_valid || advance;

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ch.ready) begin
      inq_valid <= in_ch.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      inq_byte <= in_ch.in_byte;
      inq_eot  <= in_ch.end_of_text;
    end
  end

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (inq_byte),
    .end_of_text (inq_eot),
    .advance     (advance),
    .dec         (dec)
  );

  jsu_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && dec.count != 3'd0),
    .load_data (dec),
    .room      (buf_room),
    .out_ch    (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_BUSY |-> out_ch.last && !out_ch.byte_valid)
    else $error("status beat not final or carries a byte");

  a_byte_beat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.byte_valid |-> out_ch.status == ST_BUSY)
    else $error("byte beat carries a status");

  a_inq_hold: assert property (@(posedge clk) disable iff (rst)
    inq_valid && !advance |=> inq_valid && $stable(inq_byte) && $stable(inq_eot))
    else $error("held input item lost or changed");
`endif

endmodule
